// ===== design/urq_pkg.sv =====
package urq_pkg;

  // default geometry of the receive ring
  localparam int SlotsDefault      = 4;
  localparam int MaxPayloadDefault = 512;

  // udp header size in bytes
  localparam int HdrBytes = 8;

  // depth of the queue between front and back (power of two)
  localparam int QueueDepth = 2;

  // width of the delivered length field on the port
  localparam int LenOutW = 10;

  // item kinds on the input channel
  localparam logic ACT_SEGMENT = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  // result kinds on the output channel
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // reception status codes
  typedef enum logic [1:0] {
    RX_ACCEPTED   = 2'd0,
    RX_TOO_SHORT  = 2'd1,
    RX_BAD_LENGTH = 2'd2,
    RX_QUEUE_FULL = 2'd3
  } rx_status_e;

  // one queued input transaction
  typedef struct packed {
    logic        action;
    logic [7:0]  seg_byte;
    logic        seg_last;
    logic [31:0] src_ip;
    logic [15:0] read_size;
  } item_t;

endpackage

// ===== design/udp_receive_queue_unit.sv =====
// UDP receive ring. One input channel carries two kinds of transaction:
// a segment byte (action 0, header first, seg_last on the final byte,
// src_ip sampled with the first byte) or a read request (action 1).
// A segment produces one reception status transaction at its final byte;
// earlier bytes produce none. A read request always produces one read
// response: the next payload byte of the head datagram with its length,
// sender address and port, byte_last on the byte that releases the slot,
// or empty_res when nothing is queued. read_size is sampled on the first
// read of each datagram. The ring holds SLOTS-1 datagrams.
// A segment status is registered in the output register; a read response
// passes the payload store read register, then the output register. The
// back end takes one segment byte per cycle while the output is not
// stalled; a read request holds it in ST_RD_WAIT because of the registered
// read of the payload store. A two-entry input queue decouples the input channel from the back end.
// Reset empties the input queue and the ring; payload and slot contents
// are undefined until written. While out_stall_i is high on a valid result
// it holds, the back end halts and in_stall_o rises once the input queue is full.
module udp_receive_queue_unit #(
  parameter int SLOTS       = urq_pkg::SlotsDefault,
  parameter int MAX_PAYLOAD = urq_pkg::MaxPayloadDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [7:0]                  seg_byte_i,
  input  logic                        seg_last_i,
  input  logic [31:0]                 src_ip_i,
  input  logic [15:0]                 read_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [1:0]                  status_o,
  output logic                        empty_res_o,
  output logic [7:0]                  data_byte_o,
  output logic                        byte_last_o,
  output logic [urq_pkg::LenOutW-1:0] payload_len_o,
  output logic [31:0]                 pkt_src_ip_o,
  output logic [15:0]                 pkt_src_port_o
);
  import urq_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  // input queue and classification
  urq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .seg_byte_i   (seg_byte_i),
    .seg_last_i   (seg_last_i),
    .src_ip_i     (src_ip_i),
    .read_size_i  (read_size_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // ring, payload store and result register
  urq_back #(
    .SLOTS       (SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_pop_o     (item_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .empty_res_o    (empty_res_o),
    .data_byte_o    (data_byte_o),
    .byte_last_o    (byte_last_o),
    .payload_len_o  (payload_len_o),
    .pkt_src_ip_o   (pkt_src_ip_o),
    .pkt_src_port_o (pkt_src_port_o)
  );

endmodule

// ===== design/urq_front.sv =====
module urq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          action_i,
  input  logic [7:0]    seg_byte_i,
  input  logic          seg_last_i,
  input  logic [31:0]   src_ip_i,
  input  logic [15:0]   read_size_i,
  output logic          item_valid_o,
  output urq_pkg::item_t item_o,
  input  logic          item_pop_i
);
  import urq_pkg::*;

  localparam int QAW = $clog2(QueueDepth);

  item_t            entry_q [QueueDepth];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAW:0]     count_q, count_d;
  logic             push;
  logic             pop;
  item_t            item_in;

  // classify and pack the incoming transaction
  always_comb begin
    item_in.action    = (action_i == ACT_READ) ? ACT_READ : ACT_SEGMENT;
    item_in.seg_byte  = seg_byte_i;
    item_in.seg_last  = seg_last_i;
    item_in.src_ip    = src_ip_i;
    item_in.read_size = read_size_i;
  end

  assign in_stall_o   = (count_q == (QAW + 1)'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_valid_o && item_pop_i;
  assign item_o       = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== design/urq_back.sv =====
module urq_back #(
  parameter int SLOTS       = urq_pkg::SlotsDefault,
  parameter int MAX_PAYLOAD = urq_pkg::MaxPayloadDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  urq_pkg::item_t              item_i,
  output logic                        item_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [1:0]                  status_o,
  output logic                        empty_res_o,
  output logic [7:0]                  data_byte_o,
  output logic                        byte_last_o,
  output logic [urq_pkg::LenOutW-1:0] payload_len_o,
  output logic [31:0]                 pkt_src_ip_o,
  output logic [15:0]                 pkt_src_port_o
);
  import urq_pkg::*;

  localparam int SW        = $clog2(SLOTS);
  localparam int SLOT_AW   = $clog2(MAX_PAYLOAD);
  localparam int MEM_AW    = SW + SLOT_AW;
  localparam int MEM_DEPTH = SLOTS * (2 ** SLOT_AW);
  localparam int LEN_W     = $clog2(MAX_PAYLOAD + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RD_WAIT
  } state_e;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] idx);
    return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
  endfunction

  state_e              state_q, state_d;

  // ring and parser state
  logic [SW-1:0]       head_q, head_d;
  logic [SW-1:0]       tail_q, tail_d;
  logic [15:0]         byte_count_q, byte_count_d;
  logic [15:0]         hdr_port_q, hdr_port_d;
  logic [15:0]         hdr_len_q, hdr_len_d;
  logic [31:0]         seg_ip_q, seg_ip_d;
  logic [LEN_W-1:0]    read_pos_q, read_pos_d;
  logic [LEN_W-1:0]    read_limit_q, read_limit_d;
  logic                read_busy_q, read_busy_d;
  logic                has_data_q, has_data_d;

  // slot descriptors
  logic [LEN_W-1:0]    slot_len_q  [SLOTS];
  logic [31:0]         slot_ip_q   [SLOTS];
  logic [15:0]         slot_port_q [SLOTS];
  logic                slot_we;
  logic [LEN_W-1:0]    slot_len_wr;

  // payload store
  logic [7:0]          mem_q [MEM_DEPTH];
  logic [7:0]          mem_rdata_q;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic                mem_re;
  logic [MEM_AW-1:0]   mem_raddr;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                kind_q, kind_d;
  rx_status_e          status_q, status_d;
  logic                empty_q, empty_d;
  logic [7:0]          data_q, data_d;
  logic                last_q, last_d;
  logic [LenOutW-1:0]  len_q, len_d;
  logic [31:0]         ip_q, ip_d;
  logic [15:0]         port_q, port_d;

  logic                out_free;
  logic                take;

  // receive path helpers
  logic [31:0]         ip_eff;
  logic [15:0]         port_eff;
  logic [15:0]         len_eff;
  logic [15:0]         pay_off;
  logic [16:0]         total;
  logic [15:0]         plen;

  // read path helpers
  logic [LEN_W-1:0]    rd_limit;
  logic [LEN_W-1:0]    rd_pos;
  logic [LEN_W-1:0]    rd_pos_n;
  logic                rd_has;
  logic                rd_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign item_pop_o = (state_q == ST_IDLE) && out_free;
  assign take       = item_pop_o && item_valid_i;

  // header field capture for the current segment byte
  always_comb begin
    ip_eff   = (byte_count_q == 16'd0) ? item_i.src_ip : seg_ip_q;
    port_eff = hdr_port_q;
    len_eff  = hdr_len_q;
    unique case (byte_count_q)
      16'd0:   port_eff = {item_i.seg_byte, hdr_port_q[7:0]};
      16'd1:   port_eff = {hdr_port_q[15:8], item_i.seg_byte};
      16'd4:   len_eff  = {item_i.seg_byte, hdr_len_q[7:0]};
      16'd5:   len_eff  = {hdr_len_q[15:8], item_i.seg_byte};
      default: ;
    endcase
    pay_off = byte_count_q - 16'(HdrBytes);
    total   = {1'b0, byte_count_q} + 17'd1;
    plen    = len_eff - 16'(HdrBytes);
    if (plen > 16'(MAX_PAYLOAD)) begin
      plen = 16'(MAX_PAYLOAD);
    end
  end

  // read limit and position for the current read request
  always_comb begin
    if (read_busy_q) begin
      rd_limit = read_limit_q;
      rd_pos   = read_pos_q;
    end else begin
      rd_pos = '0;
      if (16'(slot_len_q[head_q]) < item_i.read_size) begin
        rd_limit = slot_len_q[head_q];
      end else begin
        rd_limit = LEN_W'(item_i.read_size);
      end
    end
    rd_has   = (rd_pos < rd_limit);
    rd_pos_n = rd_has ? rd_pos + 1'b1 : rd_pos;
    rd_last  = (rd_pos_n >= rd_limit);
  end

  // back-end control
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    byte_count_d = byte_count_q;
    hdr_port_d   = hdr_port_q;
    hdr_len_d    = hdr_len_q;
    seg_ip_d     = seg_ip_q;
    read_pos_d   = read_pos_q;
    read_limit_d = read_limit_q;
    read_busy_d  = read_busy_q;
    has_data_d   = has_data_q;

    slot_we     = 1'b0;
    slot_len_wr = LEN_W'(plen);
    mem_we      = 1'b0;
    mem_waddr   = {tail_q, pay_off[SLOT_AW-1:0]};
    mem_re      = 1'b0;
    mem_raddr   = {head_q, rd_pos[SLOT_AW-1:0]};

    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    status_d    = status_q;
    empty_d     = empty_q;
    data_d      = data_q;
    last_d      = last_q;
    len_d       = len_q;
    ip_d        = ip_q;
    port_d      = port_q;

    unique case (state_q)
      ST_IDLE: begin
        if (take && item_i.action == ACT_SEGMENT) begin
          // segment byte: parse header, store payload, commit at the end
          mem_we = (byte_count_q >= 16'(HdrBytes)) && (pay_off < 16'(MAX_PAYLOAD));
          if (!item_i.seg_last) begin
            seg_ip_d   = ip_eff;
            hdr_port_d = port_eff;
            hdr_len_d  = len_eff;
            if (byte_count_q != 16'hFFFF) begin
              byte_count_d = byte_count_q + 16'd1;
            end
          end else begin
            if (total < 17'(HdrBytes)) begin
              status_d = RX_TOO_SHORT;
            end else if (len_eff < 16'(HdrBytes) || {1'b0, len_eff} > total) begin
              status_d = RX_BAD_LENGTH;
            end else if (next_slot(tail_q) == head_q) begin
              status_d = RX_QUEUE_FULL;
            end else begin
              status_d = RX_ACCEPTED;
              slot_we  = 1'b1;
              tail_d   = next_slot(tail_q);
            end
            byte_count_d = '0;
            hdr_port_d   = '0;
            hdr_len_d    = '0;
            seg_ip_d     = '0;
            out_valid_d  = 1'b1;
            kind_d       = KIND_STATUS;
            empty_d      = 1'b0;
            data_d       = '0;
            last_d       = 1'b0;
            len_d        = '0;
            ip_d         = '0;
            port_d       = '0;
          end
        end else if (take) begin
          kind_d   = KIND_READ;
          status_d = RX_ACCEPTED;
          data_d   = '0;
          if (!read_busy_q && head_q == tail_q) begin
            // nothing queued
            out_valid_d = 1'b1;
            empty_d     = 1'b1;
            last_d      = 1'b0;
            len_d       = '0;
            ip_d        = '0;
            port_d      = '0;
          end else begin
            // fetch one payload byte, result completes in ST_RD_WAIT
            empty_d    = 1'b0;
            last_d     = rd_last;
            len_d      = LenOutW'(rd_limit);
            ip_d       = slot_ip_q[head_q];
            port_d     = slot_port_q[head_q];
            mem_re     = rd_has;
            has_data_d = rd_has;
            if (rd_last) begin
              read_busy_d  = 1'b0;
              read_pos_d   = '0;
              read_limit_d = '0;
              head_d       = next_slot(head_q);
            end else begin
              read_busy_d  = 1'b1;
              read_pos_d   = rd_pos_n;
              read_limit_d = rd_limit;
            end
            state_d = ST_RD_WAIT;
          end
        end
      end
      ST_RD_WAIT: begin
        out_valid_d = 1'b1;
        data_d      = has_data_q ? mem_rdata_q : 8'd0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, ring pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      byte_count_q <= '0;
      hdr_port_q   <= '0;
      hdr_len_q    <= '0;
      seg_ip_q     <= '0;
      read_pos_q   <= '0;
      read_limit_q <= '0;
      read_busy_q  <= 1'b0;
      has_data_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      byte_count_q <= byte_count_d;
      hdr_port_q   <= hdr_port_d;
      hdr_len_q    <= hdr_len_d;
      seg_ip_q     <= seg_ip_d;
      read_pos_q   <= read_pos_d;
      read_limit_q <= read_limit_d;
      read_busy_q  <= read_busy_d;
      has_data_q   <= has_data_d;
      out_valid_q  <= out_valid_d;
      kind_q       <= kind_d;
      status_q     <= status_d;
      empty_q      <= empty_d;
      data_q       <= data_d;
      last_q       <= last_d;
      len_q        <= len_d;
      ip_q         <= ip_d;
      port_q       <= port_d;
    end
  end

  // slot descriptors written on commit
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_len_q[tail_q]  <= slot_len_wr;
      slot_ip_q[tail_q]   <= ip_eff;
      slot_port_q[tail_q] <= port_eff;
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= item_i.seg_byte;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign status_o       = status_q;
  assign empty_res_o    = empty_q;
  assign data_byte_o    = data_q;
  assign byte_last_o    = last_q;
  assign payload_len_o  = len_q;
  assign pkt_src_ip_o   = ip_q;
  assign pkt_src_port_o = port_q;

endmodule
